### rtl/core/svpm_pkg.sv
package svpm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_VOLT_LIMIT   = 2'd0;
	localparam logic [1:0] REG_SUPPLY_VOLTS = 2'd1;
	localparam logic [1:0] REG_TIMER_TOP    = 2'd2;

	// register reset values
	localparam logic [14:0] VOLT_LIMIT_RST   = 15'd2481;
	localparam logic [14:0] SUPPLY_VOLTS_RST = 15'd4301;
	localparam logic [15:0] TIMER_TOP_RST    = 16'd1000;

	// sector codes
	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	// fixed point constants
	localparam int CORDIC_N = 16;
	localparam int DIV_N    = 31;
	localparam logic [14:0] IDX_MAX = 15'd18907;
	localparam logic signed [33:0] SQRT3_Q15 = 34'sd56756;
	localparam logic signed [43:0] INV_GAIN_Q16 = 44'sd39797;
	localparam logic signed [31:0] ROT_X0_Q30 = 32'sd652032874;
	localparam logic [24:0] DIV6_RECIP = 25'd22369622;
	localparam logic [23:0] QUARTER_TURN = 24'h400000;
	localparam logic signed [25:0] HALF_TURN = 26'sd8388608;

	// arctangent table, 2^-24 turn units
	localparam logic signed [25:0] ATAN_TAB [CORDIC_N] = '{
		26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050,
		26'sd166669, 26'sd83416, 26'sd41718, 26'sd20860,
		26'sd10430, 26'sd5215, 26'sd2608, 26'sd1304,
		26'sd652, 26'sd326, 26'sd163, 26'sd81
	};

	// one item as it travels down the pipeline
	typedef struct packed {
		logic               dzero;
		logic signed [15:0] q;
		logic [23:0]        ang;
		logic signed [26:0] vx;
		logic signed [26:0] vy;
		logic signed [25:0] acc;
		logic               neg;
		logic [30:0]        num;
		logic [14:0]        rem;
		logic [30:0]        quo;
		logic signed [15:0] idx;
		logic [2:0]         sec;
		logic signed [31:0] rx1;
		logic signed [31:0] ry1;
		logic signed [25:0] rz1;
		logic signed [31:0] rx2;
		logic signed [31:0] ry2;
		logic signed [25:0] rz2;
	} svpm_item_t;

endpackage

### rtl/core/svpm_in_if.sv
interface svpm_in_if #(
	parameter int VOLT_BITS  = 16,
	parameter int ANGLE_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [VOLT_BITS-1:0] q_volts;
	logic signed [VOLT_BITS-1:0] d_volts;
	logic [ANGLE_BITS-1:0]       elec_angle;

	modport source (output valid, q_volts, d_volts, elec_angle, input ready);
	modport sink (input valid, q_volts, d_volts, elec_angle, output ready);
endinterface

### rtl/core/svpm_out_if.sv
interface svpm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic [2:0]  sector_num;
	logic        fault;

	modport source (output valid, compare_a, compare_b, compare_c, sector_num, fault,
		input ready);
	modport sink (input valid, compare_a, compare_b, compare_c, sector_num, fault,
		output ready);
endinterface

### rtl/core/svpm_vec_cell.sv
module svpm_vec_cell import svpm_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_v,
	input  svpm_item_t in_item,
	output logic       out_v,
	output svpm_item_t out_item
);
	svpm_item_t nxt;

	// one vectoring micro-rotation toward the x axis
	always_comb begin
		nxt = in_item;
		if (in_item.vy > 27'sd0) begin
			nxt.vx  = in_item.vx + (in_item.vy >>> STAGE);
			nxt.vy  = in_item.vy - (in_item.vx >>> STAGE);
			nxt.acc = in_item.acc + ATAN_TAB[STAGE];
		end else begin
			nxt.vx  = in_item.vx - (in_item.vy >>> STAGE);
			nxt.vy  = in_item.vy + (in_item.vx >>> STAGE);
			nxt.acc = in_item.acc - ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= nxt;
		end
	end
endmodule

### rtl/core/svpm_div_cell.sv
module svpm_div_cell import svpm_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [14:0] divisor,
	input  logic        in_v,
	input  svpm_item_t  in_item,
	output logic        out_v,
	output svpm_item_t  out_item
);
	svpm_item_t  nxt;
	logic [15:0] trial;

	// one restoring division step, most significant numerator bit first
	always_comb begin
		nxt = in_item;
		trial = {in_item.rem, in_item.num[DIV_N-1-STAGE]};
		if (trial >= {1'b0, divisor}) begin
			nxt.rem = 15'(trial - {1'b0, divisor});
			nxt.quo = {in_item.quo[DIV_N-2:0], 1'b1};
		end else begin
			nxt.rem = trial[14:0];
			nxt.quo = {in_item.quo[DIV_N-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= nxt;
		end
	end
endmodule

### rtl/core/svpm_rot_cell.sv
module svpm_rot_cell import svpm_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_v,
	input  svpm_item_t in_item,
	output logic       out_v,
	output svpm_item_t out_item
);
	svpm_item_t nxt;

	// one rotation step on both sine lanes
	always_comb begin
		nxt = in_item;
		if (in_item.rz1 >= 26'sd0) begin
			nxt.rx1 = in_item.rx1 - (in_item.ry1 >>> STAGE);
			nxt.ry1 = in_item.ry1 + (in_item.rx1 >>> STAGE);
			nxt.rz1 = in_item.rz1 - ATAN_TAB[STAGE];
		end else begin
			nxt.rx1 = in_item.rx1 + (in_item.ry1 >>> STAGE);
			nxt.ry1 = in_item.ry1 - (in_item.rx1 >>> STAGE);
			nxt.rz1 = in_item.rz1 + ATAN_TAB[STAGE];
		end
		if (in_item.rz2 >= 26'sd0) begin
			nxt.rx2 = in_item.rx2 - (in_item.ry2 >>> STAGE);
			nxt.ry2 = in_item.ry2 + (in_item.rx2 >>> STAGE);
			nxt.rz2 = in_item.rz2 - ATAN_TAB[STAGE];
		end else begin
			nxt.rx2 = in_item.rx2 + (in_item.ry2 >>> STAGE);
			nxt.ry2 = in_item.ry2 - (in_item.rx2 >>> STAGE);
			nxt.rz2 = in_item.rz2 + ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= nxt;
		end
	end
endmodule

### rtl/core/svpwm_phase_voltage_modulator.sv
// Space vector PWM modulator fed by d/q voltage commands.
// Input channel in_ch carries q_volts, d_volts (signed Q8.8) and elec_angle
// (fraction of a turn); output channel out_ch carries three center-aligned
// compare values, the sector and a fault flag. Both use valid/ready; a
// transfer happens on a clock edge with valid and ready high.
// The configuration port writes volt_limit, supply_volts and the timer period
// (indexes 0, 1, 2) whenever cfg_we is high; write only while no items are
// in flight.
// The datapath is one row of pipeline cells: 16 vectoring CORDIC cells,
// 31 restoring divider cells (one quotient bit each), 16 rotation CORDIC
// cells and the input, gain, setup, sector, argument, product, duty and
// compare registers, 72 register stages in all. One item is accepted every
// cycle while the receiver keeps up.
// The whole row advances together: when the output register holds a result
// the receiver has not taken, the row freezes and in_ch.ready drops.
// Reset clears all valid bits and loads the register defaults; the block is
// ready in the first cycle after reset.
module svpwm_phase_voltage_modulator import svpm_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int VOLT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	svpm_in_if.sink     in_ch,
	svpm_out_if.source  out_ch
);
	localparam logic [23:0] ANG_KEEP = ~24'((25'd1 << (24 - ANGLE_BITS)) - 25'd1);

	logic [14:0] volt_limit_q;
	logic [14:0] supply_volts_q;
	logic [15:0] timer_top_q;
	logic [14:0] sup_eff;
	logic        en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_limit_q   <= VOLT_LIMIT_RST;
			supply_volts_q <= SUPPLY_VOLTS_RST;
			timer_top_q    <= TIMER_TOP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_VOLT_LIMIT:   volt_limit_q   <= cfg_wdata[14:0];
				REG_SUPPLY_VOLTS: supply_volts_q <= cfg_wdata[14:0];
				REG_TIMER_TOP:    timer_top_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign sup_eff = (supply_volts_q == 15'd0) ? 15'd1 : supply_volts_q;

	logic out_v_q;
	assign en = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	// ---------------- input stage: clamp and vector setup
	logic signed [32:0] q_w, d_w, lim_w, q_c, d_c;
	logic signed [15:0] q16, d16;
	logic signed [26:0] dx, qy;
	svpm_item_t in_item;

	always_comb begin
		q_w = 33'($signed(in_ch.q_volts[VOLT_BITS-1:0]));
		d_w = 33'($signed(in_ch.d_volts[VOLT_BITS-1:0]));
		lim_w = 33'({1'b0, volt_limit_q});
		q_c = (q_w > lim_w) ? lim_w : ((q_w < -lim_w) ? -lim_w : q_w);
		d_c = (d_w > lim_w) ? lim_w : ((d_w < -lim_w) ? -lim_w : d_w);
		q16 = 16'(q_c);
		d16 = 16'(d_c);
		dx = 27'(d16) <<< 8;
		qy = 27'(q16) <<< 8;
		in_item = '0;
		in_item.q = q16;
		in_item.dzero = (d16 == 16'sd0);
		in_item.ang = 24'(in_ch.elec_angle[ANGLE_BITS-1:0]) << (24 - ANGLE_BITS);
		if (d16 < 16'sd0) begin
			in_item.vx = -dx;
			in_item.vy = -qy;
			in_item.acc = HALF_TURN;
		end else begin
			in_item.vx = dx;
			in_item.vy = qy;
			in_item.acc = 26'sd0;
		end
	end

	svpm_item_t vec_it [0:CORDIC_N];
	logic       vec_v  [0:CORDIC_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_v[0] <= 1'b0;
		end else if (en) begin
			vec_v[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_it[0] <= in_item;
		end
	end

	// vectoring cordic row
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_vec
		svpm_vec_cell #(.STAGE(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_v(vec_v[i]), .in_item(vec_it[i]),
			.out_v(vec_v[i+1]), .out_item(vec_it[i+1])
		);
	end

	// ---------------- gain correction and divider setup
	svpm_item_t         item_m1, item_m2;
	logic signed [43:0] mprod_m1;
	logic               v_m1, v_m2;
	svpm_item_t         m2_nxt;
	logic [16:0]        mag, qabs, numsel;

	always_comb begin
		mag = 17'(mprod_m1 >>> 24);
		qabs = (item_m1.q < 16'sd0) ? 17'(-item_m1.q) : 17'(item_m1.q);
		qabs[16] = 1'b0;
		m2_nxt = item_m1;
		numsel = item_m1.dzero ? qabs : mag;
		m2_nxt.neg = item_m1.dzero && (item_m1.q < 16'sd0);
		m2_nxt.num = 31'(numsel) << 15;
		m2_nxt.rem = '0;
		m2_nxt.quo = '0;
		if (item_m1.dzero) begin
			m2_nxt.ang = item_m1.ang + QUARTER_TURN;
		end else begin
			m2_nxt.ang = item_m1.ang + (item_m1.acc[23:0] & ANG_KEEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m1 <= vec_v[CORDIC_N];
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_m1  <= vec_it[CORDIC_N];
			mprod_m1 <= 44'(vec_it[CORDIC_N].vx) * INV_GAIN_Q16;
			item_m2  <= m2_nxt;
		end
	end

	// divider row
	svpm_item_t div_it [0:DIV_N];
	logic       div_v  [0:DIV_N];

	assign div_it[0] = item_m2;
	assign div_v[0]  = v_m2;

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		svpm_div_cell #(.STAGE(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .divisor(sup_eff),
			.in_v(div_v[k]), .in_item(div_it[k]),
			.out_v(div_v[k+1]), .out_item(div_it[k+1])
		);
	end

	// ---------------- index saturation, sector and sine arguments
	svpm_item_t  item_p1, item_p2, p1_nxt, p2_nxt;
	logic [23:0] frac_p1;
	logic        v_p1, v_p2;
	logic [14:0] qmag;
	logic [26:0] ang6;
	logic [24:0] rest;
	logic [49:0] ph1_w, ph2_w;

	always_comb begin
		p1_nxt = div_it[DIV_N];
		qmag = (div_it[DIV_N].quo > 31'(IDX_MAX)) ? IDX_MAX : div_it[DIV_N].quo[14:0];
		p1_nxt.idx = div_it[DIV_N].neg ? -16'($signed({1'b0, qmag})) :
			16'($signed({1'b0, qmag}));
		ang6 = 27'(div_it[DIV_N].ang) * 27'd6;
		p1_nxt.sec = ang6[26:24];
	end

	always_comb begin
		p2_nxt = item_p1;
		rest = 25'd16777216 - 25'(frac_p1);
		ph1_w = 50'(rest) * 50'(DIV6_RECIP);
		ph2_w = 50'(frac_p1) * 50'(DIV6_RECIP);
		p2_nxt.rx1 = ROT_X0_Q30;
		p2_nxt.ry1 = 32'sd0;
		p2_nxt.rz1 = 26'(ph1_w >> 27);
		p2_nxt.rx2 = ROT_X0_Q30;
		p2_nxt.ry2 = 32'sd0;
		p2_nxt.rz2 = 26'(ph2_w >> 27);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
		end else if (en) begin
			v_p1 <= div_v[DIV_N];
			v_p2 <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_p1 <= p1_nxt;
			frac_p1 <= ang6[23:0];
			item_p2 <= p2_nxt;
		end
	end

	// rotation cordic row, two sine lanes
	svpm_item_t rot_it [0:CORDIC_N];
	logic       rot_v  [0:CORDIC_N];

	assign rot_it[0] = item_p2;
	assign rot_v[0]  = v_p2;

	for (genvar j = 0; j < CORDIC_N; j++) begin : g_rot
		svpm_rot_cell #(.STAGE(j)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_v(rot_v[j]), .in_item(rot_it[j]),
			.out_v(rot_v[j+1]), .out_item(rot_it[j+1])
		);
	end

	// ---------------- vector times, duties and compare values
	logic signed [16:0] sin1, sin2;
	logic signed [33:0] pa1_t1, pa2_t1;
	logic signed [15:0] idx_t1, idx_t2;
	logic [2:0]         sec_t1, sec_t2, sec_t3;
	logic signed [49:0] tt1_t2, tt2_t2;
	logic               v_t1, v_t2, v_t3;
	logic signed [19:0] tv1, tv2, t0, h, ta, tb, tc;
	logic [2:0]         sec_sel;
	logic               fault_sel;
	logic [15:0]        da_t3, db_t3, dc_t3;
	logic               fault_t3;
	logic [15:0]        cmp_a_q, cmp_b_q, cmp_c_q;
	logic [2:0]         sec_q;
	logic               fault_q;

	function automatic logic [15:0] duty_clamp(logic signed [19:0] v);
		logic [15:0] r;
		if (v < 20'sd0) begin
			r = 16'd0;
		end else if (v > 20'sd32768) begin
			r = 16'd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] scale(logic [15:0] duty, logic [15:0] period);
		logic [31:0] p;
		p = 32'(duty) * 32'(period);
		return p[30:15];
	endfunction

	assign sin1 = 17'(rot_it[CORDIC_N].ry1 >>> 15);
	assign sin2 = 17'(rot_it[CORDIC_N].ry2 >>> 15);

	// sector switching table
	always_comb begin
		tv1 = 20'(tt1_t2 >>> 30);
		tv2 = 20'(tt2_t2 >>> 30);
		t0 = 20'sd32768 - tv1 - tv2;
		h = t0 >>> 1;
		sec_sel = sec_t2;
		fault_sel = 1'b0;
		case (sec_t2)
			SEC_0: begin ta = tv1 + tv2 + h; tb = tv2 + h; tc = h; end
			SEC_1: begin ta = tv1 + h; tb = tv1 + tv2 + h; tc = h; end
			SEC_2: begin ta = h; tb = tv1 + tv2 + h; tc = tv2 + h; end
			SEC_3: begin ta = h; tb = tv1 + h; tc = tv1 + tv2 + h; end
			SEC_4: begin ta = tv2 + h; tb = h; tc = tv1 + tv2 + h; end
			SEC_5: begin ta = tv1 + tv2 + h; tb = h; tc = tv1 + h; end
			default: begin
				ta = 20'sd0;
				tb = 20'sd0;
				tc = 20'sd0;
				fault_sel = 1'b1;
				sec_sel = SEC_0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_t1 <= rot_v[CORDIC_N];
			v_t2 <= v_t1;
			v_t3 <= v_t2;
			out_v_q <= v_t3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa1_t1 <= SQRT3_Q15 * 34'(sin1);
			pa2_t1 <= SQRT3_Q15 * 34'(sin2);
			idx_t1 <= rot_it[CORDIC_N].idx;
			sec_t1 <= rot_it[CORDIC_N].sec;
			tt1_t2 <= 50'(pa1_t1) * 50'(idx_t1);
			tt2_t2 <= 50'(pa2_t1) * 50'(idx_t1);
			idx_t2 <= idx_t1;
			sec_t2 <= sec_t1;
			da_t3 <= duty_clamp(ta);
			db_t3 <= duty_clamp(tb);
			dc_t3 <= duty_clamp(tc);
			sec_t3 <= sec_sel;
			fault_t3 <= fault_sel;
			cmp_a_q <= scale(da_t3, timer_top_q);
			cmp_b_q <= scale(db_t3, timer_top_q);
			cmp_c_q <= scale(dc_t3, timer_top_q);
			sec_q <= sec_t3;
			fault_q <= fault_t3;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.compare_a  = cmp_a_q;
	assign out_ch.compare_b  = cmp_b_q;
	assign out_ch.compare_c  = cmp_c_q;
	assign out_ch.sector_num = sec_q;
	assign out_ch.fault      = fault_q;

`ifndef SYNTHESIS
	// the sector always lies in range, so fault never shows
	a_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !fault_q)
		else $error("fault raised on a valid result");

	// a duty of at most one never exceeds the period
	a_cmp_le_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (cmp_a_q <= timer_top_q && cmp_b_q <= timer_top_q &&
			cmp_c_q <= timer_top_q))
		else $error("compare value above period");

	// a frozen row keeps its items
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_t3) && $stable(v_p2) && $stable(v_m2)))
		else $error("pipeline moved while stalled");

	// the index never exceeds its saturation bound
	a_idx_sat: assert property (@(posedge clk) disable iff (!arst_n)
		v_t2 |-> (idx_t2 <= 16'sd18907 && idx_t2 >= -16'sd18907))
		else $error("modulation index out of bound");
`endif
endmodule

### test/tb_svpwm_phase_voltage_modulator.sv
`timescale 1ns / 1ps
module tb_svpwm_phase_voltage_modulator import svpm_pkg::*; ();

	localparam int LATENCY = 72;

	typedef struct {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [2:0]  sec;
		logic        flt;
	} duty_set_t;

	typedef struct {
		logic [15:0] q;
		logic [15:0] d;
		logic [15:0] ang;
		bit          known;
		duty_set_t   res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	svpm_in_if #(.VOLT_BITS(16), .ANGLE_BITS(16)) in_ch ();
	svpm_out_if out_ch ();

	svpwm_phase_voltage_modulator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the configuration registers
	logic [14:0] lim_sh = VOLT_LIMIT_RST;
	logic [14:0] sup_sh = SUPPLY_VOLTS_RST;
	logic [15:0] per_sh = TIMER_TOP_RST;

	duty_set_t duty_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit recv_hold = 0;

	longint atan_t [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
		20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sine_q15(longint phi);
		longint x, y, z, xs, ys;
		x = 652032874; y = 0; z = phi;
		for (int i = 0; i < 16; i++) begin
			xs = floor_shr(x, i); ys = floor_shr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_t[i];
			end else begin
				x += ys; y -= xs; z += atan_t[i];
			end
		end
		return floor_shr(y, 15);
	endfunction

	function automatic duty_set_t svpwm_duties(logic [15:0] qr, logic [15:0] dr,
		logic [15:0] ar);
		longint lim, sup, q, d, idx, x, y, acc, mag, xs, ys, t1, t2, t0, h, ta, tb, tc;
		longint ang, sec, u;
		duty_set_t r;
		lim = lim_sh;
		sup = (sup_sh == 0) ? 1 : sup_sh;
		q = sat(longint'($signed(qr)), -lim, lim);
		d = sat(longint'($signed(dr)), -lim, lim);
		ang = ar;
		if (d == 0) begin
			idx = (q * 32768) / sup;
			ang = (ang + 16384) & 16'hFFFF;
		end else begin
			x = d * 256; y = q * 256; acc = 0;
			if (x < 0) begin
				x = -x; y = -y; acc = 8388608;
			end
			for (int i = 0; i < 16; i++) begin
				xs = floor_shr(x, i); ys = floor_shr(y, i);
				if (y > 0) begin
					x += ys; y -= xs; acc += atan_t[i];
				end else begin
					x -= ys; y += xs; acc -= atan_t[i];
				end
			end
			mag = floor_shr(x * 39797, 24);
			idx = (mag * 32768) / sup;
			u = (acc & 24'hFFFFFF) >> 8;
			ang = (ang + u) & 16'hFFFF;
		end
		idx = sat(idx, -18907, 18907);
		sec = (ang * 6) >> 16;
		u = ((ang * 6) & 16'hFFFF) << 8;
		t1 = floor_shr(56756 * sine_q15((16777216 - u) / 6) * idx, 30);
		t2 = floor_shr(56756 * sine_q15(u / 6) * idx, 30);
		t0 = 32768 - t1 - t2;
		h = floor_shr(t0, 1);
		r.flt = 1'b0;
		case (sec)
			SEC_0: begin ta = t1 + t2 + h; tb = t2 + h; tc = h; end
			SEC_1: begin ta = t1 + h; tb = t1 + t2 + h; tc = h; end
			SEC_2: begin ta = h; tb = t1 + t2 + h; tc = t2 + h; end
			SEC_3: begin ta = h; tb = t1 + h; tc = t1 + t2 + h; end
			SEC_4: begin ta = t2 + h; tb = h; tc = t1 + t2 + h; end
			SEC_5: begin ta = t1 + t2 + h; tb = h; tc = t1 + h; end
			default: begin
				ta = 0; tb = 0; tc = 0; r.flt = 1'b1; sec = 0;
			end
		endcase
		ta = sat(ta, 0, 32768); tb = sat(tb, 0, 32768); tc = sat(tc, 0, 32768);
		r.a = 16'((ta * per_sh) >> 15);
		r.b = 16'((tb * per_sh) >> 15);
		r.c = 16'((tc * per_sh) >> 15);
		r.sec = sec[2:0];
		return r;
	endfunction

	// one item into the block; the expectation is queued at the transfer
	task automatic send_item(logic [15:0] q, logic [15:0] d, logic [15:0] a,
		bit known, duty_set_t res);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.q_volts <= q;
		in_ch.d_volts <= d;
		in_ch.elec_angle <= a;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		duty_q.push_back(known ? res : svpwm_duties(q, d, a));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_VOLT_LIMIT: lim_sh = val[14:0];
			REG_SUPPLY_VOLTS: sup_sh = val[14:0];
			REG_TIMER_TOP: per_sh = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait until every expected result is back, plus the pipeline depth
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (duty_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_volt();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'h0000;
			2: return 16'($urandom_range(4000)) ^ {16{$urandom_range(1) == 1}};
			default: return 16'($signed($urandom_range(6000)) - 3000);
		endcase
	endfunction

	// receiver: random stalls, and a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
		end
	end

	// result check on every output transfer
	always @(posedge clk) begin
		duty_set_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (duty_q.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				e = duty_q.pop_front();
				if (out_ch.compare_a !== e.a) begin
					$error("compare_a exp %0d got %0d", e.a, out_ch.compare_a); errors++;
				end
				if (out_ch.compare_b !== e.b) begin
					$error("compare_b exp %0d got %0d", e.b, out_ch.compare_b); errors++;
				end
				if (out_ch.compare_c !== e.c) begin
					$error("compare_c exp %0d got %0d", e.c, out_ch.compare_c); errors++;
				end
				if (out_ch.sector_num !== e.sec) begin
					$error("sector_num exp %0d got %0d", e.sec, out_ch.sector_num); errors++;
				end
				if (out_ch.fault !== e.flt) begin
					$error("fault exp %0d got %0d", e.flt, out_ch.fault); errors++;
				end
			end
		end
	end

	// directed rows; zero commands give 50% duty: 16384*1000>>15 = 500
	stim_row_t dir_tab[] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1, '{16'd500, 16'd500, 16'd500, SEC_1, 1'b0}},
		'{16'h0000, 16'h0000, 16'hFFFF, 1, '{16'd500, 16'd500, 16'd500, SEC_1, 1'b0}},
		'{16'h7FFF, 16'h0000, 16'h0000, 0, '{0, 0, 0, 0, 0}},
		'{16'h8000, 16'h0000, 16'h0000, 0, '{0, 0, 0, 0, 0}},
		'{16'h7FFF, 16'h7FFF, 16'h4000, 0, '{0, 0, 0, 0, 0}},
		'{16'h8000, 16'h8000, 16'hC000, 0, '{0, 0, 0, 0, 0}},
		'{16'h0000, 16'h7FFF, 16'h2AAA, 0, '{0, 0, 0, 0, 0}},
		'{16'h0000, 16'h8000, 16'h2AAB, 0, '{0, 0, 0, 0, 0}},
		'{16'h0100, 16'hFF00, 16'h5555, 0, '{0, 0, 0, 0, 0}},
		'{16'hFF00, 16'h0100, 16'h8000, 0, '{0, 0, 0, 0, 0}},
		'{16'h0400, 16'h0000, 16'hAAAA, 0, '{0, 0, 0, 0, 0}},
		'{16'hFC00, 16'h0000, 16'hD555, 0, '{0, 0, 0, 0, 0}},
		'{16'h0001, 16'hFFFF, 16'h1234, 0, '{0, 0, 0, 0, 0}},
		'{16'h09B1, 16'h09B1, 16'hFFFF, 0, '{0, 0, 0, 0, 0}}
	};

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_volt(), rand_volt(), 16'($urandom), 0, '{0, 0, 0, 0, 0});
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.q_volts = '0;
		in_ch.d_volts = '0;
		in_ch.elec_angle = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		foreach (dir_tab[i])
			send_item(dir_tab[i].q, dir_tab[i].d, dir_tab[i].ang, dir_tab[i].known,
				dir_tab[i].res);
		drain();

		// extremes of the registers
		write_reg(REG_VOLT_LIMIT, 16'h7FFF);
		write_reg(REG_SUPPLY_VOLTS, 16'd1);
		write_reg(REG_TIMER_TOP, 16'hFFFF);
		foreach (dir_tab[i])
			send_item(dir_tab[i].q, dir_tab[i].d, dir_tab[i].ang, 0, '{0, 0, 0, 0, 0});
		drain();
		write_reg(REG_VOLT_LIMIT, 16'd0);
		write_reg(REG_SUPPLY_VOLTS, 16'h0000);
		write_reg(REG_TIMER_TOP, 16'd1);
		run_random(10);
		drain();

		// random phases with varying settings and idling
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_VOLT_LIMIT, 16'($urandom_range(32767)));
			write_reg(REG_SUPPLY_VOLTS, 16'($urandom_range(300, 32767)) | 16'h8000);
			write_reg(REG_TIMER_TOP, 16'($urandom_range(1, 65535)));
			send_idle = (ph == 0) ? 29 : (ph == 1) ? 82 : 0;
			recv_idle = (ph == 0) ? 82 : (ph == 1) ? 29 : 0;
			run_random(200);
			drain();
		end

		// long receiver hold-off so the pipeline fills and stalls the input
		write_reg(REG_VOLT_LIMIT, VOLT_LIMIT_RST);
		write_reg(REG_SUPPLY_VOLTS, SUPPLY_VOLTS_RST);
		write_reg(REG_TIMER_TOP, TIMER_TOP_RST);
		fork
			begin
				recv_hold = 1;
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
			run_random(120);
		join
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("FAILURE");
		$finish;
	end
endmodule
